/* rtl/dlb_pkg.sv */
package dlb_pkg;

    // register map
    localparam int unsigned NUM_REGS   = 5;
    localparam int unsigned ADDR_W     = 5;
    localparam logic [2:0]  REG_NEAR   = 3'd0;
    localparam logic [2:0]  REG_FAR    = 3'd1;
    localparam logic [2:0]  REG_FOCAL  = 3'd2;
    localparam logic [2:0]  REG_WIDTH  = 3'd3;
    localparam logic [2:0]  REG_HEIGHT = 3'd4;

    localparam logic [31:0] NEAR_RST   = 32'd6554;
    localparam logic [31:0] FAR_RST    = 32'd655360000;
    localparam logic [15:0] FOCAL_RST  = 16'd480;
    localparam logic [12:0] WIDTH_RST  = 13'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;

    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam logic [23:0] ONE_Z = 24'd8388608;

    // one quotient bit per stage
    localparam int unsigned DIV_STEPS  = 32;
    localparam int unsigned PIPE_DEPTH = 2 * DIV_STEPS + 7;

    typedef struct packed {
        logic [23:0]        idx;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               zok;
        logic signed [15:0] noise;
        logic signed [15:0] kx;
        logic signed [15:0] ky;
    } t_side;

endpackage

/* rtl/depth_linearize_backproject.sv */
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+-----------------------------------------
// pixel in | in        | i_valid / o_ready        | z-buffer value, noise, column, row, rgb
// point out| out       | o_valid / i_ready        | index, rgb, depth, point x/y, depth_valid
// apb      | in        | psel/penable/pwrite      | five config registers at 4*index
//
// one pixel is taken every cycle unless the output is full and blocked
// the depth divider (32 stages, one quotient bit each) and the two projection
// dividers (32 stages each) set the depth of the pipe
// synchronous active-low reset clears the valid bits and loads the register defaults
// a stall at the output freezes every stage together; nothing is dropped or repeated
module depth_linearize_backproject
    import dlb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // pixel input
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [23:0]         i_zbuffer_value,
    input  logic signed [15:0]  i_noise_factor,
    input  logic [11:0]         i_source_column,
    input  logic [11:0]         i_source_row,
    input  logic [7:0]          i_red_in,
    input  logic [7:0]          i_green_in,
    input  logic [7:0]          i_blue_in,
    // point output
    output logic                o_valid,
    input  logic                i_ready,
    output logic [23:0]         o_pixel_index,
    output logic [7:0]          o_red_out,
    output logic [7:0]          o_green_out,
    output logic [7:0]          o_blue_out,
    output logic [31:0]         o_depth_value,
    output logic signed [31:0]  o_point_x,
    output logic signed [31:0]  o_point_y,
    output logic                o_depth_valid,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // stage positions in the pipe
    localparam int unsigned ST_M   = DIV_STEPS + 2;  // noise product
    localparam int unsigned ST_S   = DIV_STEPS + 3;  // saturated depth
    localparam int unsigned ST_Q0  = DIV_STEPS + 5;  // projection divider entry
    localparam int unsigned ST_END = PIPE_DEPTH - 1;

    // ---------------------------------------------------------------- config
    logic [31:0] r_near, r_far;
    logic [15:0] r_focal;
    logic [12:0] r_width, r_height;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= NEAR_RST;
            r_far    <= FAR_RST;
            r_focal  <= FOCAL_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_NEAR:   r_near  <= pwdata;
                REG_FAR:    r_far   <= pwdata;
                REG_FOCAL:  r_focal <= pwdata[15:0];
                // clamp image size to the supported maximum
                REG_WIDTH:  r_width <= ({1'b0, pwdata[12:0]} > 14'(MAX_WIDTH)) ?
                                       13'(MAX_WIDTH) : pwdata[12:0];
                REG_HEIGHT: r_height <= ({1'b0, pwdata[12:0]} > 14'(MAX_HEIGHT)) ?
                                        13'(MAX_HEIGHT) : pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_NEAR:   prdata = r_near;
            REG_FAR:    prdata = r_far;
            REG_FOCAL:  prdata = {16'b0, r_focal};
            REG_WIDTH:  prdata = {19'b0, r_width};
            REG_HEIGHT: prdata = {19'b0, r_height};
            default:    prdata = 32'b0;
        endcase
    end

    // ---------------------------------------------------------------- flow control
    // the whole pipe moves together; it holds only when the output is full and blocked
    logic  en;
    logic  r_vld  [0:PIPE_DEPTH-1];
    t_side r_side [0:PIPE_DEPTH-1];
    t_side n_side;

    assign en      = !r_vld[ST_END] || i_ready;
    assign o_ready = en;

    // ---------------------------------------------------------------- stage 0: geometry
    logic signed [14:0] frow;
    logic signed [28:0] frow_w;
    logic [23:0]        zc;

    always_comb begin
        // flip bottom-up row to top-down; may go negative past image height
        frow   = $signed({2'b0, r_height}) - 15'sd1 - $signed({3'b0, i_source_row});
        frow_w = 29'(frow) * 29'($signed({1'b0, r_width}));
        zc     = ONE_Z - i_zbuffer_value;

        n_side.idx   = 24'(frow_w + $signed({17'b0, i_source_column}));
        n_side.red   = i_red_in;
        n_side.green = i_green_in;
        n_side.blue  = i_blue_in;
        n_side.zok   = (i_zbuffer_value <= ONE_Z);
        n_side.noise = i_noise_factor;
        n_side.kx    = $signed({3'b0, i_source_column, 1'b0}) - $signed({3'b0, r_width});
        n_side.ky    = $signed({3'b0, r_height}) - (16'(frow) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PIPE_DEPTH; j++) r_vld[j] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < PIPE_DEPTH; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int j = 1; j < PIPE_DEPTH; j++) r_side[j] <= r_side[j-1];
        end
    end

    // stage 0 products for the depth denominator and numerator
    logic [55:0] r_pa, r_pb;
    logic [63:0] r_pnf;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa  <= zc * r_far;
            r_pb  <= i_zbuffer_value * r_near;
            r_pnf <= r_near * r_far;
        end
    end

    // ---------------------------------------------------------------- depth divider
    // near*far*2^23 / den, restoring, one quotient bit per stage
    logic [55:0] r_drem [0:DIV_STEPS];
    logic [55:0] r_dden [0:DIV_STEPS];
    logic [31:0] r_dlow [0:DIV_STEPS];
    logic [31:0] r_dq   [0:DIV_STEPS];
    logic        r_ddz  [0:DIV_STEPS];

    logic [55:0] den0;
    assign den0 = r_pa + r_pb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dden[0] <= den0;
            r_drem[0] <= {1'b0, r_pnf[63:9]};
            r_dlow[0] <= {r_pnf[8:0], 23'b0};
            r_dq[0]   <= 32'b0;
            r_ddz[0]  <= (den0 == 56'b0);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_ddiv
        logic [56:0] trial;
        logic        ge;
        assign trial = {r_drem[k], r_dlow[k][DIV_STEPS-1-k]};
        assign ge    = (trial >= {1'b0, r_dden[k]});
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_drem[k+1] <= ge ? 56'(trial - {1'b0, r_dden[k]}) : trial[55:0];
                r_dden[k+1] <= r_dden[k];
                r_dlow[k+1] <= r_dlow[k];
                r_dq[k+1]   <= {r_dq[k][30:0], ge};
                r_ddz[k+1]  <= r_ddz[k];
            end
        end
    end

    // ---------------------------------------------------------------- noise and saturation
    logic [31:0] lin;
    logic [14:0] noise_pos;
    logic [46:0] r_mprod;
    logic [32:0] msh;
    logic [31:0] r_dep;

    assign lin       = r_ddz[DIV_STEPS] ? 32'b0 : r_dq[DIV_STEPS];
    // zero or negative noise gives zero depth
    assign noise_pos = (r_side[ST_M-1].noise > 16'sd0) ? r_side[ST_M-1].noise[14:0] : 15'b0;
    assign msh       = r_mprod[46:14];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mprod <= lin * noise_pos;
            if (!r_side[ST_M].zok) r_dep <= 32'b0;
            else                   r_dep <= msh[32] ? 32'hFFFF_FFFF : msh[31:0];
        end
    end

    // ---------------------------------------------------------------- projection
    // lane 0 is x, lane 1 is y; both divide depth*|k| by 2*focal (by 2 when focal is zero)
    logic [16:0] pdiv;
    assign pdiv = {((r_focal == 16'b0) ? 16'd1 : r_focal), 1'b0};

    logic [45:0] r_num  [0:1];
    logic [31:0] r_pdep [0:DIV_STEPS+1];
    logic [16:0] r_prem [0:1][0:DIV_STEPS];
    logic [31:0] r_plow [0:1][0:DIV_STEPS];
    logic [31:0] r_pq   [0:1][0:DIV_STEPS];
    logic        r_pov  [0:1][0:DIV_STEPS];
    logic [31:0] pres   [0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pdep[0] <= r_dep;
            for (int j = 1; j <= DIV_STEPS + 1; j++) r_pdep[j] <= r_pdep[j-1];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [15:0] kin;
        logic [13:0]        kmag;
        logic               neg;
        logic [31:0]        qf;
        logic               ovf;

        assign kin  = (l == 0) ? r_side[ST_S].kx : r_side[ST_S].ky;
        assign kmag = kin[15] ? 14'(-kin) : kin[13:0];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_num[l]     <= r_dep * kmag;
                // a quotient of 2^32 or more is flagged and saturated at the end
                r_pov[l][0]  <= ({3'b0, r_num[l][45:32]} >= pdiv);
                r_prem[l][0] <= {3'b0, r_num[l][45:32]};
                r_plow[l][0] <= r_num[l][31:0];
                r_pq[l][0]   <= 32'b0;
            end
        end

        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
            logic [17:0] trial;
            logic        ge;
            assign trial = {r_prem[l][k], r_plow[l][k][DIV_STEPS-1-k]};
            assign ge    = (trial >= {1'b0, pdiv});
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_prem[l][k+1] <= ge ? 17'(trial - {1'b0, pdiv}) : trial[16:0];
                    r_plow[l][k+1] <= r_plow[l][k];
                    r_pq[l][k+1]   <= {r_pq[l][k][30:0], ge};
                    r_pov[l][k+1]  <= r_pov[l][k];
                end
            end
        end

        // truncate toward zero, then saturate to signed 32 bits
        assign neg = (l == 0) ? r_side[ST_END-1].kx[15] : r_side[ST_END-1].ky[15];
        assign qf  = r_pq[l][DIV_STEPS];
        assign ovf = r_pov[l][DIV_STEPS];

        always_comb begin
            if (neg) pres[l] = 32'd0 - ((ovf || qf > 32'h8000_0000) ? 32'h8000_0000 : qf);
            else     pres[l] = (ovf || qf > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qf;
        end
    end

    // ---------------------------------------------------------------- output register
    logic [31:0] r_ox, r_oy, r_odep;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox   <= pres[0];
            r_oy   <= pres[1];
            r_odep <= r_pdep[DIV_STEPS+1];
        end
    end

    assign o_valid       = r_vld[ST_END];
    assign o_pixel_index = r_side[ST_END].idx;
    assign o_red_out     = r_side[ST_END].red;
    assign o_green_out   = r_side[ST_END].green;
    assign o_blue_out    = r_side[ST_END].blue;
    assign o_depth_valid = r_side[ST_END].zok;
    assign o_depth_value = r_odep;
    assign o_point_x     = $signed(r_ox);
    assign o_point_y     = $signed(r_oy);

    // ---------------------------------------------------------------- checks
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_depth_valid |-> o_depth_value == 32'b0 && o_point_x == 32'sb0
                                       && o_point_y == 32'sb0)
        else $error("invalid pixel carries a non-zero depth or point");

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_depth_value == 32'b0 |-> o_point_x == 32'sb0 && o_point_y == 32'sb0)
        else $error("zero depth gave a non-zero point");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld[ST_Q0]) && $stable(r_pq[0][DIV_STEPS]))
        else $error("pipe moved during a stall");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with an empty output stage");

endmodule

/* dv/dlb_checker.sv */
`timescale 1ns / 100ps

module dlb_checker
    import dlb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [23:0]        i_zbuffer_value,
    input  logic signed [15:0] i_noise_factor,
    input  logic [11:0]        i_source_column,
    input  logic [11:0]        i_source_row,
    input  logic [7:0]         i_red_in,
    input  logic [7:0]         i_green_in,
    input  logic [7:0]         i_blue_in,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [23:0]        o_pixel_index,
    input  logic [7:0]         o_red_out,
    input  logic [7:0]         o_green_out,
    input  logic [7:0]         o_blue_out,
    input  logic [31:0]        o_depth_value,
    input  logic signed [31:0] o_point_x,
    input  logic signed [31:0] o_point_y,
    input  logic               o_depth_valid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_errors,
    output int                 o_pending,
    output logic               o_progress
);

    typedef struct packed {
        logic [23:0] idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] depth;
        logic [31:0] px;
        logic [31:0] py;
        logic        dvalid;
    } t_point;

    logic [31:0] near_q, far_q;
    logic [15:0] focal_q;
    logic [12:0] width_q, height_q;
    t_point      points_due[$];

    // depth*k/div toward zero, clipped to signed 32 bits
    function automatic logic [31:0] backproject(logic [31:0] depth, longint k, longint div);
        longint unsigned mag, v;
        mag = (k < 0) ? -k : k;
        v   = (longint'(depth) * mag) / div;
        if (k < 0) begin
            if (v > 64'h8000_0000) v = 64'h8000_0000;
            return 32'(64'h1_0000_0000 - v);
        end
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic t_point point_of(logic [23:0] z, logic signed [15:0] noise,
                                        logic [11:0] col, logic [11:0] row,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_point p;
        longint frow, w, h, div;
        logic [127:0] den, lin, dep;
        w    = width_q;
        h    = height_q;
        frow = h - 1 - row;
        p    = '0;
        p.idx   = 24'(longint'(col) + frow * w);
        p.red   = r;
        p.green = g;
        p.blue  = b;
        if (z <= ONE_Z) begin
            p.dvalid = 1'b1;
            den = 128'(ONE_Z - z) * far_q + 128'(z) * near_q;
            lin = 0;
            if (den != 0) lin = ((128'(near_q) * far_q) << 23) / den;
            dep = 0;
            if (noise > 0) begin
                dep = (lin * 128'(noise)) >> 14;
                if (dep > 128'hFFFF_FFFF) dep = 128'hFFFF_FFFF;
            end
            p.depth = dep[31:0];
            div  = (focal_q == 0) ? 2 : 2 * longint'(focal_q);
            p.px = backproject(p.depth, 2 * longint'(col) - w, div);
            p.py = backproject(p.depth, h - 2 * frow, div);
        end
        return p;
    endfunction

    task automatic compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_point want;
        o_progress <= i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready));
        if (!i_rst_n) begin
            near_q   <= NEAR_RST;
            far_q    <= FAR_RST;
            focal_q  <= FOCAL_RST;
            width_q  <= WIDTH_RST;
            height_q <= HEIGHT_RST;
            o_errors = 0;
        end else begin
            // register writes, with size clamping
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_NEAR:   near_q  <= pwdata;
                    REG_FAR:    far_q   <= pwdata;
                    REG_FOCAL:  focal_q <= pwdata[15:0];
                    REG_WIDTH:  width_q <= (pwdata[12:0] > MAX_WIDTH_DEF)
                                           ? 13'(MAX_WIDTH_DEF) : pwdata[12:0];
                    REG_HEIGHT: height_q <= (pwdata[12:0] > MAX_HEIGHT_DEF)
                                            ? 13'(MAX_HEIGHT_DEF) : pwdata[12:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                points_due.push_back(point_of(i_zbuffer_value, i_noise_factor,
                    i_source_column, i_source_row, i_red_in, i_green_in, i_blue_in));
            end
            if (o_valid && i_ready) begin
                if (points_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_errors++;
                end else begin
                    want = points_due.pop_front();
                    compare("pixel_index", 32'(want.idx), 32'(o_pixel_index));
                    compare("red_out", 32'(want.red), 32'(o_red_out));
                    compare("green_out", 32'(want.green), 32'(o_green_out));
                    compare("blue_out", 32'(want.blue), 32'(o_blue_out));
                    compare("depth_value", want.depth, o_depth_value);
                    compare("point_x", want.px, o_point_x);
                    compare("point_y", want.py, o_point_y);
                    compare("depth_valid", 32'(want.dvalid), 32'(o_depth_valid));
                end
            end
        end
        o_pending <= points_due.size();
    end

endmodule

/* dv/tb_depth_linearize_backproject.sv */
`timescale 1ns / 100ps

module tb_depth_linearize_backproject;
    import dlb_pkg::*;

    localparam int LATENCY   = PIPE_DEPTH;
    localparam int STALL_MAX = 20000;   // watchdog: cycles with no transfer at all
    localparam int N_RANDOM  = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [23:0]        i_zbuffer_value = '0;
    logic signed [15:0] i_noise_factor = '0;
    logic [11:0]        i_source_column = '0;
    logic [11:0]        i_source_row = '0;
    logic [7:0]         i_red_in = '0;
    logic [7:0]         i_green_in = '0;
    logic [7:0]         i_blue_in = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [23:0]        o_pixel_index;
    logic [7:0]         o_red_out, o_green_out, o_blue_out;
    logic [31:0]        o_depth_value;
    logic signed [31:0] o_point_x, o_point_y;
    logic               o_depth_valid;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int   n_errors, n_pending;
    logic progress;
    int   idle_cycles = 0;
    int   hold_len = 0;     // long receiver stall requested by the stimulus
    int   held = 0;         // receiver's own count of the long stall

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    depth_linearize_backproject dut (.*);

    dlb_checker u_checker (
        .*,
        .o_errors   (n_errors),
        .o_pending  (n_pending),
        .o_progress (progress)
    );

    // receiver: own stall pattern, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (held < hold_len) begin
            i_ready <= 1'b0;
            held    <= held + 1;
        end else if (($time / 4000) % 3 == 2) begin
            i_ready <= 1'b1;    // stretches with no stalling
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if (!i_rst_n || progress) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] index, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one pixel transfer; valid stays high across back-to-back items
    task automatic send_pixel(logic [23:0] z, logic [15:0] noise, logic [11:0] col,
                              logic [11:0] row, logic [23:0] rgb);
        i_valid         <= 1'b1;
        i_zbuffer_value <= z;
        i_noise_factor  <= noise;
        i_source_column <= col;
        i_source_row    <= row;
        {i_red_in, i_green_in, i_blue_in} <= rgb;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // mostly in-range z with a share of invalid ones and both extremes
    task automatic random_pixel;
        logic [23:0] z;
        logic [15:0] noise;
        case ($urandom_range(0, 9))
            0: z = 24'($urandom_range(ONE_Z + 1, 24'hFF_FFFF));
            1: z = ($urandom_range(0, 1) != 0) ? ONE_Z : 24'd0;
            default: z = 24'($urandom_range(0, ONE_Z));
        endcase
        case ($urandom_range(0, 7))
            0: noise = 16'($urandom);
            1: noise = 16'h7FFF;
            default: noise = 16'(16384 + $signed($urandom_range(0, 2000)) - 1000);
        endcase
        send_pixel(z, noise, 12'($urandom), 12'($urandom), 24'($urandom));
    endtask

    task automatic random_burst(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n > 0; k++, n--) random_pixel();
            if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 12));
        end
    endtask

    task automatic load_setting(logic [31:0] nr, logic [31:0] fr, logic [15:0] fl,
                                logic [12:0] w, logic [12:0] h);
        reg_write(REG_NEAR, nr);
        reg_write(REG_FAR, fr);
        reg_write(REG_FOCAL, 32'(fl));
        reg_write(REG_WIDTH, 32'(w));
        reg_write(REG_HEIGHT, 32'(h));
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes and the special cases, at reset settings
        send_pixel(24'd0, 16'd16384, 12'd0, 12'd0, 24'h000000);
        send_pixel(ONE_Z, 16'd16384, 12'd4095, 12'd4095, 24'hFFFFFF);
        send_pixel(ONE_Z + 24'd1, 16'd16384, 12'd320, 12'd240, 24'hA5A5A5);  // invalid z
        send_pixel(24'hFF_FFFF, 16'h7FFF, 12'd100, 12'd10, 24'h5A5A5A);
        send_pixel(24'd4_000_000, 16'h8000, 12'd0, 12'd479, 24'h123456);    // most negative noise
        send_pixel(24'd4_000_000, 16'd0, 12'd639, 12'd0, 24'h654321);       // zero noise
        send_pixel(24'd8_388_000, 16'h7FFF, 12'd0, 12'd0, 24'h010203);      // z near far plane
        send_pixel(24'd1, 16'd16384, 12'd640, 12'd480, 24'h0F0F0F);         // past width and height
        drain();

        // zero focal length, near/far zero and oversize width/height
        load_setting(32'd0, 32'd0, 16'd0, 13'h1FFF, 13'h1FFF);
        send_pixel(24'd12345, 16'd16384, 12'd7, 12'd9, 24'h808080);
        send_pixel(ONE_Z, 16'h7FFF, 12'd4095, 12'd0, 24'h7F7F7F);
        drain();

        // extremes of near/far with tiny image
        load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 13'd1, 13'd1);
        send_pixel(24'd0, 16'h7FFF, 12'd0, 12'd0, 24'h112233);
        send_pixel(24'd8_000_000, 16'h7FFF, 12'd4095, 12'd4095, 24'h445566);
        drain();

        // random phases over several settings
        load_setting(32'd6554, 32'd655360000, 16'd480, 13'd640, 13'd480);
        random_burst(N_RANDOM / 4);
        // long receiver hold-off while the sender keeps offering
        hold_len = 300;
        random_burst(200);
        drain();   // sender waits for every result

        load_setting(32'd1, 32'd65536 * 100, 16'hFFFF, 13'd4096, 13'd4096);
        random_burst(N_RANDOM / 4);
        drain();

        load_setting($urandom_range(1, 65536), 32'd65536 * 50, 16'd300, 13'd1920, 13'd1080);
        random_burst(N_RANDOM / 4);
        drain();

        load_setting($urandom, $urandom, 16'($urandom), 13'($urandom), 13'($urandom));
        random_burst(N_RANDOM / 4 - 200);
        drain();

        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/dlb_pkg.sv
rtl/depth_linearize_backproject.sv
dv/dlb_checker.sv
dv/tb_depth_linearize_backproject.sv
